### rtl/core/tfn_pkg.sv
// Shared types and constants for the TF-IDF weighting block with L2 normalization.
// No dependencies; rtl/core files but tfn_ram use this package by scoped names.
`timescale 1ns / 1ps

package tfn_pkg;

	localparam int MAX_TERMS = 64;
	localparam int FRAC_BITS = 16;

	localparam int TF_W   = 16;
	localparam int DF_W   = 32;
	localparam int N_W    = 32;
	localparam int X_W    = DF_W + 1;
	localparam int W_W    = 40;
	localparam int LOG_W  = 6 + FRAC_BITS;
	localparam int IDF_W  = LOG_W + 1;
	localparam int PROD_W = TF_W + 1 + IDF_W;
	localparam int SUM_W  = 64;
	localparam int NORM_W = 32;
	localparam int DIV_W  = W_W + FRAC_BITS;
	localparam int QM_W   = FRAC_BITS + 1;
	localparam int IDX_W  = 6;
	localparam int NW_W   = 18;
	localparam int IT_W   = 5;
	localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W  = $clog2(MAX_TERMS + 1);

	localparam logic signed [63:0] W_MAX = (64'sd1 <<< (W_W - 1)) - 64'sd1;
	localparam logic signed [63:0] W_MIN = -(64'sd1 <<< (W_W - 1));

	typedef struct packed {
		logic signed [W_W-1:0] weight;
		logic                  last;
	} tfn_item_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_NORM,
		F_SQ,
		F_MUL,
		F_PUSH
	} front_state_t;

	typedef enum logic [3:0] {
		B_POP,
		B_SQ,
		B_ACC,
		B_RINIT,
		B_ROOT,
		B_RD,
		B_LOAD,
		B_DIV,
		B_FIN,
		B_OUT,
		B_DONE
	} back_state_t;

endpackage

### rtl/core/tfn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tfn_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/core/tfn_front.sv
// Front part: accepts terms, computes idf with an iterative log2 unit and the weight.
// Depends on tfn_pkg; pushes finished weights into tfn_queue.
`timescale 1ns / 1ps

module tfn_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [tfn_pkg::N_W-1:0]   cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [tfn_pkg::TF_W-1:0]  term_hits,
	input  logic [tfn_pkg::DF_W-1:0]  doc_frequency,
	input  logic                      last_term,
	output logic                      push,
	output tfn_pkg::tfn_item_t        push_item,
	input  logic                      full
);

	tfn_pkg::front_state_t state_q, state_nx;

	logic [tfn_pkg::N_W-1:0]             total_docs_q;
	logic [tfn_pkg::TF_W-1:0]            tf_q;
	logic [tfn_pkg::DF_W-1:0]            df_q;
	logic                                last_q;
	logic [tfn_pkg::X_W-1:0]             n_q;
	logic [5:0]                          e_q;
	logic [31:0]                         m_q;
	logic [tfn_pkg::FRAC_BITS-1:0]       frac_q;
	logic [tfn_pkg::IT_W-1:0]            it_q;
	logic                                sel_q;
	logic [tfn_pkg::LOG_W-1:0]           ln_q;
	logic signed [tfn_pkg::IDF_W-1:0]    idf_q;
	logic signed [tfn_pkg::PROD_W-1:0]   prod_s2;

	logic [63:0]                         sq;
	logic [32:0]                         t;
	logic [31:0]                         m_nx;
	logic [tfn_pkg::FRAC_BITS-1:0]       frac_nx;
	logic                                log_done;
	logic [tfn_pkg::LOG_W-1:0]           log_res;
	logic signed [63:0]                  p64;
	logic signed [tfn_pkg::W_W-1:0]      w_sat;

	// one squaring step of the mantissa per cycle
	assign sq      = 64'(m_q) * 64'(m_q);
	assign t       = sq[63:31];
	assign m_nx    = t[32] ? t[32:1] : t[31:0];
	assign frac_nx = {frac_q[tfn_pkg::FRAC_BITS-2:0], t[32]};

	always_comb begin
		log_done = 1'b0;
		log_res  = '0;
		if (state_q == tfn_pkg::F_NORM && n_q == '0) begin
			log_done = 1'b1;
		end else if (state_q == tfn_pkg::F_SQ &&
				it_q == tfn_pkg::IT_W'(tfn_pkg::FRAC_BITS - 1)) begin
			log_done = 1'b1;
			log_res  = {e_q, frac_nx};
		end
	end

	assign p64 = 64'(prod_s2);

	always_comb begin
		if (p64 > tfn_pkg::W_MAX) begin
			w_sat = tfn_pkg::W_MAX[tfn_pkg::W_W-1:0];
		end else if (p64 < tfn_pkg::W_MIN) begin
			w_sat = tfn_pkg::W_MIN[tfn_pkg::W_W-1:0];
		end else begin
			w_sat = p64[tfn_pkg::W_W-1:0];
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tfn_pkg::F_IDLE: begin
				if (in_valid) state_nx = tfn_pkg::F_NORM;
			end
			tfn_pkg::F_NORM: begin
				if (log_done) begin
					state_nx = sel_q ? tfn_pkg::F_MUL : tfn_pkg::F_NORM;
				end else if (n_q[tfn_pkg::X_W-1]) begin
					state_nx = tfn_pkg::F_SQ;
				end
			end
			tfn_pkg::F_SQ: begin
				if (log_done) state_nx = sel_q ? tfn_pkg::F_MUL : tfn_pkg::F_NORM;
			end
			tfn_pkg::F_MUL:  state_nx = tfn_pkg::F_PUSH;
			tfn_pkg::F_PUSH: begin
				if (!full) state_nx = tfn_pkg::F_IDLE;
			end
			default: state_nx = tfn_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		in_ready         = (state_q == tfn_pkg::F_IDLE);
		push             = (state_q == tfn_pkg::F_PUSH) && !full;
		push_item.weight = w_sat;
		push_item.last   = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tfn_pkg::F_IDLE;
			total_docs_q <= tfn_pkg::N_W'(1);
		end else begin
			state_q <= state_nx;
			if (cfg_wr_en) total_docs_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tfn_pkg::F_IDLE: begin
				if (in_valid) begin
					tf_q   <= term_hits;
					df_q   <= doc_frequency;
					last_q <= last_term;
					n_q    <= tfn_pkg::X_W'(total_docs_q);
					e_q    <= 6'd32;
					sel_q  <= 1'b0;
				end
			end
			tfn_pkg::F_NORM: begin
				// walk the leading one up to the top bit
				if (n_q != '0 && !n_q[tfn_pkg::X_W-1]) begin
					n_q <= n_q << 1;
					e_q <= e_q - 6'd1;
				end
				if (n_q[tfn_pkg::X_W-1]) begin
					m_q    <= n_q[tfn_pkg::X_W-1:1];
					frac_q <= '0;
					it_q   <= '0;
				end
			end
			tfn_pkg::F_SQ: begin
				m_q    <= m_nx;
				frac_q <= frac_nx;
				it_q   <= it_q + tfn_pkg::IT_W'(1);
			end
			tfn_pkg::F_MUL: begin
				prod_s2 <= $signed({1'b0, tf_q}) * idf_q;
			end
			default: ;
		endcase
		if (log_done) begin
			if (!sel_q) begin
				ln_q  <= log_res;
				n_q   <= tfn_pkg::X_W'(df_q) + tfn_pkg::X_W'(1);
				e_q   <= 6'd32;
				sel_q <= 1'b1;
			end else begin
				idf_q <= $signed({1'b0, ln_q}) - $signed({1'b0, log_res});
			end
		end
	end

endmodule

### rtl/core/tfn_queue.sv
// Two-entry queue of finished weights between the front and back parts.
// Depends on tfn_pkg for the item type.
`timescale 1ns / 1ps

module tfn_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  tfn_pkg::tfn_item_t push_item,
	output logic               full,
	input  logic               pop,
	output tfn_pkg::tfn_item_t head,
	output logic               head_valid
);

	tfn_pkg::tfn_item_t mem_q [2];
	logic               wp_q;
	logic               rp_q;
	logic [1:0]         cnt_q;

	assign full       = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head       = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_item;
	end

endmodule

### rtl/core/tfn_back.sv
// Back part: stores weights, sums squares, takes the square root and divides each weight.
// Depends on tfn_pkg and tfn_ram.
`timescale 1ns / 1ps

module tfn_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tfn_pkg::tfn_item_t              head,
	input  logic                            head_valid,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tfn_pkg::IDX_W-1:0]       term_index,
	output logic signed [tfn_pkg::NW_W-1:0] norm_weight,
	output logic                            overflow,
	output logic                            last_out
);

	tfn_pkg::back_state_t state_q, state_nx;

	logic [tfn_pkg::CNT_W-1:0]  cnt_q;
	logic                       drop_q;
	logic [tfn_pkg::SUM_W-1:0]  sum_q;
	logic [tfn_pkg::W_W-1:0]    mag_q;
	logic                       last_q;
	logic [tfn_pkg::SUM_W-1:0]  sq_s2;
	logic [tfn_pkg::SUM_W-1:0]  x_q;
	logic [tfn_pkg::SUM_W-1:0]  res_q;
	logic [tfn_pkg::IT_W-1:0]   it_q;
	logic [tfn_pkg::NORM_W-1:0] norm_q;
	logic [tfn_pkg::ADDR_W-1:0] k_q;
	logic [tfn_pkg::DIV_W-1:0]  rem_q;
	logic [tfn_pkg::DIV_W-1:0]  dv_q;
	logic [tfn_pkg::QM_W-1:0]   qacc_q;
	logic                       neg_q;
	logic [tfn_pkg::IDX_W-1:0]  idx_q;
	logic [tfn_pkg::NW_W-1:0]   nw_q;
	logic                       ovf_q;
	logic                       lst_q;

	logic                       full_store;
	logic                       we;
	logic [tfn_pkg::W_W-1:0]    rdata;
	logic signed [tfn_pkg::W_W-1:0] w_rd;
	logic [tfn_pkg::W_W-1:0]    mag_rd;
	logic                       clamp;
	logic [tfn_pkg::SUM_W:0]    acc;
	logic [tfn_pkg::SUM_W-1:0]  bitv;
	logic [tfn_pkg::SUM_W-1:0]  trial;
	logic                       rge;
	logic [tfn_pkg::SUM_W-1:0]  res_nx;
	logic                       dge;
	logic [tfn_pkg::QM_W-1:0]   qm_cl;
	logic [63:0]                qv64;
	logic                       k_last;

	tfn_ram #(
		.WIDTH (tfn_pkg::W_W),
		.DEPTH (tfn_pkg::MAX_TERMS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (cnt_q[tfn_pkg::ADDR_W-1:0]),
		.wdata (head.weight),
		.raddr (k_q),
		.rdata (rdata)
	);

	assign full_store = (cnt_q >= tfn_pkg::CNT_W'(tfn_pkg::MAX_TERMS));
	assign w_rd       = rdata;
	assign mag_rd     = w_rd[tfn_pkg::W_W-1] ? (~rdata + tfn_pkg::W_W'(1)) : rdata;
	assign clamp      = mag_rd >= tfn_pkg::W_W'({norm_q, 1'b0});
	assign acc        = {1'b0, sum_q} + {1'b0, sq_s2};

	// restoring square root, two bits of the radicand per step
	assign bitv   = tfn_pkg::SUM_W'(1) << {it_q, 1'b0};
	assign trial  = res_q + bitv;
	assign rge    = x_q >= trial;
	assign res_nx = rge ? ((res_q >> 1) + bitv) : (res_q >> 1);

	assign dge   = rem_q >= dv_q;
	assign qm_cl = (qacc_q > (tfn_pkg::QM_W'(1) << tfn_pkg::FRAC_BITS)) ?
			(tfn_pkg::QM_W'(1) << tfn_pkg::FRAC_BITS) : qacc_q;
	assign qv64  = neg_q ? (64'd0 - 64'(qm_cl)) : 64'(qm_cl);
	assign k_last = (tfn_pkg::CNT_W'(k_q) + tfn_pkg::CNT_W'(1)) == cnt_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			tfn_pkg::B_POP: begin
				if (head_valid) begin
					if (!full_store)    state_nx = tfn_pkg::B_SQ;
					else if (head.last) state_nx = tfn_pkg::B_RINIT;
				end
			end
			tfn_pkg::B_SQ:    state_nx = tfn_pkg::B_ACC;
			tfn_pkg::B_ACC:   state_nx = last_q ? tfn_pkg::B_RINIT : tfn_pkg::B_POP;
			tfn_pkg::B_RINIT: state_nx = tfn_pkg::B_ROOT;
			tfn_pkg::B_ROOT: begin
				if (it_q == '0) begin
					state_nx = (cnt_q == '0) ? tfn_pkg::B_DONE : tfn_pkg::B_RD;
				end
			end
			tfn_pkg::B_RD: state_nx = tfn_pkg::B_LOAD;
			tfn_pkg::B_LOAD: begin
				state_nx = (norm_q == '0 || clamp) ? tfn_pkg::B_FIN : tfn_pkg::B_DIV;
			end
			tfn_pkg::B_DIV: begin
				if (it_q == '0) state_nx = tfn_pkg::B_FIN;
			end
			tfn_pkg::B_FIN: state_nx = tfn_pkg::B_OUT;
			tfn_pkg::B_OUT: begin
				if (out_ready) state_nx = k_last ? tfn_pkg::B_DONE : tfn_pkg::B_RD;
			end
			tfn_pkg::B_DONE: state_nx = tfn_pkg::B_POP;
			default:         state_nx = tfn_pkg::B_POP;
		endcase
	end

	always_comb begin
		pop         = (state_q == tfn_pkg::B_POP) && head_valid;
		we          = pop && !full_store;
		out_valid   = (state_q == tfn_pkg::B_OUT);
		term_index  = idx_q;
		norm_weight = nw_q;
		overflow    = ovf_q;
		last_out    = lst_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfn_pkg::B_POP;
			cnt_q   <= '0;
			drop_q  <= 1'b0;
			sum_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				tfn_pkg::B_POP: begin
					if (head_valid) begin
						if (full_store) drop_q <= 1'b1;
						else            cnt_q  <= cnt_q + tfn_pkg::CNT_W'(1);
					end
				end
				tfn_pkg::B_ACC: begin
					sum_q <= acc[tfn_pkg::SUM_W] ? '1 : acc[tfn_pkg::SUM_W-1:0];
				end
				tfn_pkg::B_DONE: begin
					cnt_q  <= '0;
					drop_q <= 1'b0;
					sum_q  <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tfn_pkg::B_POP: begin
				mag_q  <= head.weight[tfn_pkg::W_W-1] ?
						(~head.weight + tfn_pkg::W_W'(1)) : head.weight;
				last_q <= head.last;
			end
			tfn_pkg::B_SQ: begin
				sq_s2 <= (mag_q[tfn_pkg::W_W-1:32] != '0) ? '1 :
						64'(mag_q[31:0]) * 64'(mag_q[31:0]);
			end
			tfn_pkg::B_RINIT: begin
				x_q   <= sum_q;
				res_q <= '0;
				it_q  <= tfn_pkg::IT_W'(31);
				k_q   <= '0;
			end
			tfn_pkg::B_ROOT: begin
				if (rge) x_q <= x_q - trial;
				res_q <= res_nx;
				it_q  <= it_q - tfn_pkg::IT_W'(1);
				if (it_q == '0) norm_q <= res_nx[tfn_pkg::NORM_W-1:0];
			end
			tfn_pkg::B_LOAD: begin
				neg_q <= w_rd[tfn_pkg::W_W-1];
				rem_q <= tfn_pkg::DIV_W'(mag_rd) << tfn_pkg::FRAC_BITS;
				dv_q  <= tfn_pkg::DIV_W'(norm_q) << tfn_pkg::FRAC_BITS;
				it_q  <= tfn_pkg::IT_W'(tfn_pkg::FRAC_BITS);
				if (norm_q == '0)  qacc_q <= '0;
				else if (clamp)    qacc_q <= tfn_pkg::QM_W'(1) << tfn_pkg::FRAC_BITS;
				else               qacc_q <= '0;
			end
			tfn_pkg::B_DIV: begin
				if (dge) rem_q <= rem_q - dv_q;
				dv_q   <= dv_q >> 1;
				qacc_q <= {qacc_q[tfn_pkg::QM_W-2:0], dge};
				it_q   <= it_q - tfn_pkg::IT_W'(1);
			end
			tfn_pkg::B_FIN: begin
				idx_q <= tfn_pkg::IDX_W'(k_q);
				nw_q  <= qv64[tfn_pkg::NW_W-1:0];
				ovf_q <= drop_q;
				lst_q <= k_last;
			end
			tfn_pkg::B_OUT: begin
				if (out_ready) k_q <= k_q + tfn_pkg::ADDR_W'(1);
			end
			default: ;
		endcase
	end

endmodule

### rtl/core/tfidf_weight_l2_normalizer.sv
// Top level of the TF-IDF weighting block with L2 normalization.
// Depends on tfn_pkg, tfn_front, tfn_queue and tfn_back.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one term per beat with term_hits,
//   doc_frequency and last_term. Output channel (out_valid/out_ready): one
//   normalized weight per beat, in arrival order, when the document's last
//   term arrives; last_out marks the final beat of the document. cfg_wr_en and
//   cfg_wr_data write total_docs (N), by the user only while idle; not enforced.
// Operation
//   Per term the front accepts the term, runs two log2 evaluations, each a
//   normalize phase and FRAC_BITS squaring steps (no squaring for a zero
//   collection size), then a multiply and a push. The back pops, squares
//   and accumulates each term; a two-entry queue lets the front run ahead.
//   On the last term the back takes the square root of the sum, then divides
//   each weight; the divide is skipped if the norm is zero or the weight clamps.
// Reset
//   arst_n clears all control state, the running sum and the term count;
//   total_docs returns to 1. The weight store needs no clearing.
// Stalls
//   A low out_ready holds the current result beat; the back stops, the queue
//   fills and then in_ready drops. Terms past the store depth are dropped and
//   overflow is raised on every result beat of that document.

module tfidf_weight_l2_normalizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [tfn_pkg::N_W-1:0]         cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tfn_pkg::TF_W-1:0]        term_hits,
	input  logic [tfn_pkg::DF_W-1:0]        doc_frequency,
	input  logic                            last_term,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tfn_pkg::IDX_W-1:0]       term_index,
	output logic signed [tfn_pkg::NW_W-1:0] norm_weight,
	output logic                            overflow,
	output logic                            last_out
);

	tfn_pkg::tfn_item_t push_item;
	tfn_pkg::tfn_item_t head;
	logic               push;
	logic               full;
	logic               pop;
	logic               head_valid;

	// front: log2, idf and weight per term
	tfn_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.term_hits      (term_hits),
		.doc_frequency  (doc_frequency),
		.last_term      (last_term),
		.push           (push),
		.push_item      (push_item),
		.full           (full)
	);

	// hold up to two finished weights so each side stalls on its own
	tfn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	// back: store, sum of squares, root and per-weight divide
	tfn_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.term_index  (term_index),
		.norm_weight (norm_weight),
		.overflow    (overflow),
		.last_out    (last_out)
	);

endmodule

### rtl/core/tfn_checker.sv
// Port-level checks for the TF-IDF normalizer, bound to the top level.
// Depends on tfn_pkg for field widths.
`timescale 1ns / 1ps

module tfn_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [tfn_pkg::IDX_W-1:0]       term_index,
	input logic signed [tfn_pkg::NW_W-1:0] norm_weight,
	input logic                            overflow,
	input logic                            last_out
);

	logic [tfn_pkg::IDX_W-1:0] exp_idx_q;
	logic                      ovf_q;

	// track the expected index and the document's overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_idx_q <= '0;
			ovf_q     <= 1'b0;
		end else if (out_valid && out_ready) begin
			exp_idx_q <= last_out ? '0 : term_index + tfn_pkg::IDX_W'(1);
			ovf_q     <= overflow;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(norm_weight) &&
			$stable(term_index))
		else $error("result beat changed while stalled");

	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> term_index == exp_idx_q)
		else $error("result beat out of arrival order");

	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && exp_idx_q != '0 |-> overflow == ovf_q)
		else $error("overflow changed within a document");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> norm_weight <= 18'sd65536 && norm_weight >= -18'sd65536)
		else $error("normalized weight beyond one");

endmodule

bind tfidf_weight_l2_normalizer tfn_checker u_tfn_checker (.*);

### test/tb.sv
// Self-checking testbench for tfidf_weight_l2_normalizer: directed and random documents.
// Depends on tfn_pkg and the RTL under rtl/core; holds its own fixed-point predictor.
`timescale 1ns / 1ps

module tb;

	import tfn_pkg::*;

	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE_CYCLES = 400;

	typedef struct {
		logic [IDX_W-1:0]       idx;
		logic signed [NW_W-1:0] nw;
		logic                   ovf;
		logic                   lst;
	} norm_beat_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [N_W-1:0]          cfg_wr_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [TF_W-1:0]         term_hits = '0;
	logic [DF_W-1:0]         doc_frequency = '0;
	logic                    last_term = 1'b0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [IDX_W-1:0]        term_index;
	logic signed [NW_W-1:0]  norm_weight;
	logic                    overflow;
	logic                    last_out;

	// Predictor state: collection size, stored weights, running sum of squares.
	logic [63:0]             model_docs = 64'd1;
	logic signed [63:0]      model_weights [MAX_TERMS];
	logic [63:0]             model_sqsum = '0;
	int                      model_count = 0;
	bit                      model_dropped = 0;

	norm_beat_t              pending_beats [$];
	int                      fail_count = 0;
	int                      idle_cycles = 0;
	bit                      rx_fast = 0;

	tfidf_weight_l2_normalizer dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.term_hits(term_hits), .doc_frequency(doc_frequency),
		.last_term(last_term),
		.out_valid(out_valid), .out_ready(out_ready),
		.term_index(term_index), .norm_weight(norm_weight),
		.overflow(overflow), .last_out(last_out)
	);

	always #5 clk = ~clk;

	// Fixed-point log2: integer part from the leading one, fraction bits by
	// repeated squaring of a Q1.31 mantissa.
	function automatic logic [63:0] log2_q(input logic [63:0] x);
		int          e;
		logic [63:0] m, frac;
		e = 0;
		frac = '0;
		if (x == 0)
			return '0;
		for (int b = 63; b >= 0; b--) begin
			if (x[b]) begin
				e = b;
				break;
			end
		end
		m = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
		for (int i = 0; i < FRAC_BITS; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				frac = frac | 64'd1;
				m = m >> 1;
			end
		end
		return (64'(e) << FRAC_BITS) | frac;
	endfunction

	function automatic logic [63:0] sqrt_floor(input logic [63:0] x);
		logic [63:0] res, bitv;
		res = '0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x = x - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] magnitude(input logic signed [63:0] w);
		return (w < 0) ? 64'(-w) : 64'(w);
	endfunction

	// Fold one accepted term into the document; on the last term queue every
	// normalized weight the block should emit.
	task automatic predict_term(input logic [TF_W-1:0] tf, input logic [DF_W-1:0] df,
			input logic lst);
		logic signed [63:0] idf, w, q;
		logic [63:0]        mag, sq, norm, qm;
		norm_beat_t         beat;
		if (model_count >= MAX_TERMS) begin
			model_dropped = 1;
		end else begin
			idf = $signed(log2_q(model_docs)) - $signed(log2_q(64'(df) + 64'd1));
			w = $signed({48'd0, tf}) * idf;
			if (w > W_MAX)
				w = W_MAX;
			if (w < W_MIN)
				w = W_MIN;
			model_weights[model_count] = w;
			model_count++;
			mag = magnitude(w);
			sq = (mag >= 64'h1_0000_0000) ? '1 : mag * mag;
			model_sqsum = (model_sqsum > ~sq) ? '1 : model_sqsum + sq;
		end
		if (!lst)
			return;
		norm = sqrt_floor(model_sqsum);
		for (int k = 0; k < model_count; k++) begin
			q = '0;
			if (norm != 0) begin
				qm = (magnitude(model_weights[k]) << FRAC_BITS) / norm;
				if (qm > (64'd1 << FRAC_BITS))
					qm = 64'd1 << FRAC_BITS;
				q = (model_weights[k] < 0) ? -$signed(qm) : $signed(qm);
			end
			beat.idx = IDX_W'(k);
			beat.nw = q[NW_W-1:0];
			beat.ovf = model_dropped;
			beat.lst = (k + 1 == model_count);
			pending_beats.push_back(beat);
		end
		model_sqsum = '0;
		model_count = 0;
		model_dropped = 0;
	endtask

	// Present one term after an idle gap of length 'gap' and hold it until accepted.
	task automatic send_term(input logic [TF_W-1:0] tf, input logic [DF_W-1:0] df,
			input logic lst, input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		term_hits <= tf;
		doc_frequency <= df;
		last_term <= lst;
		do
			@(posedge clk);
		while (!in_ready);
		predict_term(tf, df, lst);
	endtask

	// Drop valid, drain every pending beat, let the front finish, then write total_docs.
	task automatic set_total_docs(input logic [N_W-1:0] n);
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_beats.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= n;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		model_docs = 64'(n);
	endtask

	function automatic int draw_gap(input bit busy);
		return busy ? 0 : $urandom_range(0, 17);
	endfunction

	// Extremes at the default collection size of one: zero norm, full-range fields.
	task automatic test_reset_default();
		send_term(16'd0, 32'd0, 1'b1, 0);
		send_term(16'd65535, 32'd0, 1'b0, 3);
		send_term(16'd1, 32'hFFFF_FFFF, 1'b0, 0);
		send_term(16'd65535, 32'hFFFF_FFFF, 1'b1, 0);
		send_term(16'd7, 32'd1, 1'b1, 17);
	endtask

	// Zero collection size: idf goes negative, big terms saturate the sum.
	task automatic test_zero_collection();
		send_term(16'd65535, 32'hFFFF_FFFF, 1'b0, 0);
		send_term(16'd65535, 32'hFFFF_FFFE, 1'b1, 0);
		send_term(16'd5, 32'd3, 1'b1, 2);
		send_term(16'd0, 32'hFFFF_FFFF, 1'b0, 0);
		send_term(16'd0, 32'd0, 1'b1, 0);
	endtask

	// Overfill the store; the dropped last term still triggers the emission.
	task automatic test_store_full();
		for (int i = 0; i < MAX_TERMS + 3; i++)
			send_term(16'($urandom_range(0, 65535)), $urandom,
				i == MAX_TERMS + 2, (i % 9 == 0) ? $urandom_range(0, 17) : 0);
	endtask

	// Random documents: mostly short, some long, a few past the store depth.
	task automatic test_random_docs(input int n_items);
		int sent, len, sel;
		bit busy;
		logic [TF_W-1:0] tf;
		logic [DF_W-1:0] df;
		sent = 0;
		while (sent < n_items) begin
			sel = $urandom_range(0, 99);
			len = (sel < 70) ? $urandom_range(1, 8) :
				(sel < 92) ? $urandom_range(9, 40) : $urandom_range(60, 70);
			busy = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < len; i++) begin
				tf = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) :
					16'($urandom);
				case ($urandom_range(0, 3))
					0: df = $urandom_range(0, 100);
					1: df = 32'hFFFF_FFFF - $urandom_range(0, 3);
					default: df = $urandom;
				endcase
				send_term(tf, df, i == len - 1, draw_gap(busy));
				sent++;
			end
		end
	endtask

	// Receiver: draw a stall per beat, with bursts of no stalling.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 15) == 0)
				rx_fast = ~rx_fast;
			stall = rx_fast ? 0 : $urandom_range(0, 17);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!(out_valid && out_ready));
		end
	end

	// Check each result beat against the oldest expectation.
	always @(posedge clk) begin
		norm_beat_t exp_beat;
		if (arst_n && out_valid && out_ready) begin
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected beat idx=%0d weight=%0d", $time, term_index,
					norm_weight);
				fail_count++;
			end else begin
				exp_beat = pending_beats.pop_front();
				if (term_index !== exp_beat.idx) begin
					$display("%0t: term_index expected %0d actual %0d", $time,
						exp_beat.idx, term_index);
					fail_count++;
				end
				if (norm_weight !== exp_beat.nw) begin
					$display("%0t: norm_weight idx %0d expected %0d actual %0d", $time,
						exp_beat.idx, exp_beat.nw, norm_weight);
					fail_count++;
				end
				if (overflow !== exp_beat.ovf) begin
					$display("%0t: overflow idx %0d expected %0b actual %0b", $time,
						exp_beat.idx, exp_beat.ovf, overflow);
					fail_count++;
				end
				if (last_out !== exp_beat.lst) begin
					$display("%0t: last_out idx %0d expected %0b actual %0b", $time,
						exp_beat.idx, exp_beat.lst, last_out);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when no beat moves for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < MAX_TERMS; i++)
			model_weights[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_default();
		set_total_docs(32'd0);
		test_zero_collection();
		set_total_docs(32'hFFFF_FFFF);
		test_store_full();
		test_random_docs(80);
		set_total_docs(32'd1000);
		test_random_docs(70);
		set_total_docs($urandom);
		test_random_docs(70);
		set_total_docs(32'd0);
		test_random_docs(70);
		set_total_docs(32'd1);
		test_random_docs(50);

		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending_beats.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
